// ----- design/mvt_pkg.sv -----
// Shared types and constants for the 4x4 matrix-vector transform.
// Depends on nothing; imported by every design module.
package mvt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int NUM_COMP   = 4;
   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 64;
   localparam int CSR_ADDR_W = 4;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef data_type vec_type [NUM_COMP];

   // Register indexes, in register-map order.
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ROW0_COLS01 = 4'd0,
      REG_ROW0_COLS23 = 4'd1,
      REG_ROW1_COLS01 = 4'd2,
      REG_ROW1_COLS23 = 4'd3,
      REG_ROW2_COLS01 = 4'd4,
      REG_ROW2_COLS23 = 4'd5,
      REG_ROW3_COLS01 = 4'd6,
      REG_ROW3_COLS23 = 4'd7
   } reg_idx_type;

   localparam logic [REG_W-1:0] DIAG_LO = REG_W'(64'd1 << FRAC_BITS);
   localparam logic [REG_W-1:0] DIAG_HI = REG_W'(64'd1 << (FRAC_BITS + DATA_W));

   // Identity matrix at reset.
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      DIAG_LO, '0, DIAG_HI, '0, '0, DIAG_LO, '0, DIAG_HI
   };

   // Pipeline advance enables handed to each lane.
   typedef struct packed {
      logic en_prod;
      logic en_sum;
   } pipe_ctrl_type;

   // One lane's finished component.
   typedef struct packed {
      data_type value;
      logic     sat;
   } lane_res_type;

   typedef lane_res_type lane_res_arr_type [NUM_COMP];

endpackage

// ----- design/mvt_lane.sv -----
// One row lane: four products, exact sum, shift and saturate.
// Depends on mvt_pkg.
module mvt_lane (
   input  logic                          clock,
   input  mvt_pkg::pipe_ctrl_type        ctrl,
   input  logic [mvt_pkg::REG_W-1:0]     row_cols01,
   input  logic [mvt_pkg::REG_W-1:0]     row_cols23,
   input  mvt_pkg::vec_type              vec,
   output mvt_pkg::lane_res_type         res
);
   import mvt_pkg::*;

   data_type                 coef [NUM_COMP];
   logic signed [PROD_W-1:0] prod_in [NUM_COMP];
   logic signed [PROD_W-1:0] prod_ff [NUM_COMP];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-DATA_W:0]    upper;

   assign coef[0] = row_cols01[DATA_W-1:0];
   assign coef[1] = row_cols01[REG_W-1:DATA_W];
   assign coef[2] = row_cols23[DATA_W-1:0];
   assign coef[3] = row_cols23[REG_W-1:DATA_W];

   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         prod_in[c] = PROD_W'(coef[c]) * PROD_W'(vec[c]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int c = 0; c < NUM_COMP; c++) begin
         sum_in = sum_in + SUM_W'(prod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_prod) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            prod_ff[c] <= prod_in[c];
         end
      end
      if (ctrl.en_sum) begin
         sum_ff <= sum_in;
      end
   end

   // Arithmetic shift floors; in range when all bits above bit 30 agree.
   assign shifted = sum_ff >>> FRAC_BITS;
   assign upper   = shifted[SUM_W-1:DATA_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         res.value = shifted[DATA_W-1:0];
         res.sat   = 1'b0;
      end else begin
         res.value = shifted[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
         res.sat   = 1'b1;
      end
   end

endmodule

// ----- design/mvt_merge.sv -----
// Output stage: gathers the four lane results, ORs saturation flags.
// Depends on mvt_pkg.
module mvt_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  mvt_pkg::lane_res_arr_type   lane_res,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mvt_pkg::data_type           rsp_out_x,
   output mvt_pkg::data_type           rsp_out_y,
   output mvt_pkg::data_type           rsp_out_z,
   output mvt_pkg::data_type           rsp_out_w,
   output logic                        rsp_overflow
);
   import mvt_pkg::*;

   logic     valid_ff;
   data_type x_ff, y_ff, z_ff, w_ff;
   logic     ovf_ff;
   logic     ovf_in;

   assign advance = !valid_ff || rsp_ready;
   assign ovf_in  = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat | lane_res[3].sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= lane_res[0].value;
         y_ff   <= lane_res[1].value;
         z_ff   <= lane_res[2].value;
         w_ff   <= lane_res[3].value;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_x    = x_ff;
   assign rsp_out_y    = y_ff;
   assign rsp_out_z    = z_ff;
   assign rsp_out_w    = w_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ----- design/mat4_vector_transform.sv -----
// A request passes the product, sum and output registers in turn before its result is valid.
// Throughput: one request per cycle; each stage refills as soon as it empties,
// so a stalled result only blocks once all three stages hold data.
// Reset (synchronous, active high): pipeline emptied, matrix set to identity.
// Depends on mvt_pkg, mvt_lane, mvt_merge.
module mat4_vector_transform (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mvt_pkg::data_type                req_in_x,
   input  mvt_pkg::data_type                req_in_y,
   input  mvt_pkg::data_type                req_in_z,
   input  mvt_pkg::data_type                req_in_w,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mvt_pkg::data_type                rsp_out_x,
   output mvt_pkg::data_type                rsp_out_y,
   output mvt_pkg::data_type                rsp_out_z,
   output mvt_pkg::data_type                rsp_out_w,
   output logic                             rsp_overflow,
   // matrix write port
   input  logic                             csr_we,
   input  logic [mvt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mvt_pkg::REG_W-1:0]        csr_wdata
);
   import mvt_pkg::*;

   logic [REG_W-1:0]  regs_ff [NUM_REGS];
   logic [REG_W-1:0]  regs_in [NUM_REGS];
   vec_type           vec;
   pipe_ctrl_type     ctrl;
   lane_res_arr_type  lane_res;
   logic              v_prod_ff, v_sum_ff;
   logic              out_adv;

   // ---------------- matrix registers ----------------
   // Writes beyond the last register index fall through the default arm.
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (csr_we) begin
         case (csr_addr)
            REG_ROW0_COLS01: regs_in[0] = csr_wdata;
            REG_ROW0_COLS23: regs_in[1] = csr_wdata;
            REG_ROW1_COLS01: regs_in[2] = csr_wdata;
            REG_ROW1_COLS23: regs_in[3] = csr_wdata;
            REG_ROW2_COLS01: regs_in[4] = csr_wdata;
            REG_ROW2_COLS23: regs_in[5] = csr_wdata;
            REG_ROW3_COLS01: regs_in[6] = csr_wdata;
            REG_ROW3_COLS23: regs_in[7] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= REG_RESET[i];
         end
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   // ---------------- pipeline control ----------------
   // A stage advances when empty or when the stage after it advances.
   assign ctrl.en_sum  = !v_sum_ff || out_adv;
   assign ctrl.en_prod = !v_prod_ff || ctrl.en_sum;
   assign req_ready    = ctrl.en_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_prod_ff <= 1'b0;
         v_sum_ff  <= 1'b0;
      end else begin
         if (ctrl.en_prod) begin
            v_prod_ff <= req_valid;
         end
         if (ctrl.en_sum) begin
            v_sum_ff <= v_prod_ff;
         end
      end
   end

   assign vec[0] = req_in_x;
   assign vec[1] = req_in_y;
   assign vec[2] = req_in_z;
   assign vec[3] = req_in_w;

   // ---------------- one lane per matrix row ----------------
   for (genvar r = 0; r < NUM_COMP; r++) begin : g_lane
      mvt_lane u_lane (
         .clock      (clock),
         .ctrl       (ctrl),
         .row_cols01 (regs_ff[2*r]),
         .row_cols23 (regs_ff[2*r+1]),
         .vec        (vec),
         .res        (lane_res[r])
      );
   end

   // ---------------- merge and output register ----------------
   mvt_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v_sum_ff),
      .lane_res     (lane_res),
      .advance      (out_adv),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ----- tb/sv/mvt_result_checker.sv -----
// Result checker for mat4_vector_transform: mirrors the matrix registers,
// predicts each transformed vector and compares it with the result channel.
// Depends on mvt_pkg.
module mvt_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  mvt_pkg::data_type              req_in_x,
   input  mvt_pkg::data_type              req_in_y,
   input  mvt_pkg::data_type              req_in_z,
   input  mvt_pkg::data_type              req_in_w,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  mvt_pkg::data_type              rsp_out_x,
   input  mvt_pkg::data_type              rsp_out_y,
   input  mvt_pkg::data_type              rsp_out_z,
   input  mvt_pkg::data_type              rsp_out_w,
   input  logic                           rsp_overflow,
   input  logic                           csr_we,
   input  logic [mvt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mvt_pkg::REG_W-1:0]      csr_wdata,
   output int                             error_count,
   output int                             outstanding
);
   import mvt_pkg::*;

   localparam int ACC_W = SUM_W + 2;
   localparam int IDX_W = $clog2(NUM_REGS);
   localparam longint COMP_MAX = 64'sd2147483647;
   localparam longint COMP_MIN = -64'sd2147483648;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
      data_type w;
      logic     overflow;
   } xform_type;

   logic [REG_W-1:0] matrix_regs [NUM_REGS];
   xform_type        pending_results [$];
   int               failures = 0;

   function automatic data_type matrix_entry(int row, int col);
      logic [REG_W-1:0] r;
      r = matrix_regs[IDX_W'(row * 2 + col / 2)];
      return (col % 2) ? data_type'(r[REG_W-1:DATA_W]) : data_type'(r[DATA_W-1:0]);
   endfunction

   // Exact four-product sum, floor shift, then clamp to 32 bits.
   function automatic xform_type transform_vector(data_type vx, data_type vy,
                                                  data_type vz, data_type vw);
      data_type                vin [NUM_COMP];
      data_type                comp [NUM_COMP];
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] a;
      logic signed [ACC_W-1:0] b;
      logic signed [ACC_W-1:0] shifted;
      logic                    sat;
      xform_type               t;
      vin = '{vx, vy, vz, vw};
      sat = 1'b0;
      for (int r = 0; r < NUM_COMP; r++) begin
         acc = '0;
         for (int c = 0; c < NUM_COMP; c++) begin
            a = ACC_W'(matrix_entry(r, c));
            b = ACC_W'(vin[c]);
            acc = acc + a * b;
         end
         shifted = acc >>> FRAC_BITS;
         if (shifted > COMP_MAX) begin
            comp[r] = data_type'(COMP_MAX);
            sat = 1'b1;
         end else if (shifted < COMP_MIN) begin
            comp[r] = data_type'(COMP_MIN);
            sat = 1'b1;
         end else begin
            comp[r] = data_type'(shifted[DATA_W-1:0]);
         end
      end
      t = '{comp[0], comp[1], comp[2], comp[3], sat};
      return t;
   endfunction

   always @(posedge clock) begin
      xform_type got;
      xform_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = REG_RESET[i];
         pending_results.delete();
      end else begin
         if (csr_we && csr_addr < NUM_REGS)
            matrix_regs[csr_addr[IDX_W-1:0]] = csr_wdata;
         if (req_valid && req_ready)
            pending_results.push_back(transform_vector(req_in_x, req_in_y,
                                                       req_in_z, req_in_w));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_overflow};
            if (pending_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected result: x=%h y=%h z=%h w=%h ovf=%b",
                           got.x, got.y, got.z, got.w, got.overflow);
            end else begin
               want = pending_results.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                   got.w !== want.w || got.overflow !== want.overflow) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"result mismatch: want x=%h y=%h z=%h w=%h ovf=%b,",
                               " got x=%h y=%h z=%h w=%h ovf=%b"},
                              want.x, want.y, want.z, want.w, want.overflow,
                              got.x, got.y, got.z, got.w, got.overflow);
               end
            end
         end
      end
      outstanding <= pending_results.size();
      error_count <= failures;
   end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for mat4_vector_transform: drives requests, matrix writes and
// result back-pressure; mvt_result_checker does the prediction and comparison.
// Depends on mvt_pkg, mat4_vector_transform and mvt_result_checker.
module tb;
   import mvt_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int NUM_PHASES      = 7;

   localparam data_type VMAX = 32'sh7FFFFFFF;
   localparam data_type VMIN = 32'sh80000000;
   localparam data_type ONE  = 32'sh00010000;   // 1.0 in Q16.16
   localparam data_type CORNERS [7] = '{VMAX, VMIN, 32'sd0, -32'sd1, 32'sd1, ONE, -ONE};

   typedef enum {
      MAT_IDENTITY,
      MAT_ZERO,
      MAT_ALL_NEG_ONE,
      MAT_ALL_MIN,
      MAT_ALL_MAX,
      MAT_SMALL,
      MAT_FULL,
      MAT_MIXED
   } matrix_kind_type;

   // Matrix used by each random phase, in run order.
   localparam matrix_kind_type RANDOM_PLAN [NUM_PHASES] = '{
      MAT_SMALL, MAT_MIXED, MAT_SMALL, MAT_FULL, MAT_IDENTITY, MAT_MIXED, MAT_SMALL
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   data_type              req_in_x;
   data_type              req_in_y;
   data_type              req_in_z;
   data_type              req_in_w;
   logic                  rsp_valid;
   logic                  rsp_ready;
   data_type              rsp_out_x;
   data_type              rsp_out_y;
   data_type              rsp_out_z;
   data_type              rsp_out_w;
   logic                  rsp_overflow;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [REG_W-1:0]      csr_wdata;

   int errors;
   int outstanding;
   int cycle_count = 0;
   int ready_hold  = 0;
   bit gaps_on     = 1'b1;   // sender inserts idle cycles between requests
   bit stalls_on   = 1'b1;   // receiver drops rsp_ready at random

   mat4_vector_transform u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .req_in_w     (req_in_w),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   mvt_result_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .req_in_w     (req_in_w),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_overflow (rsp_overflow),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .error_count  (errors),
      .outstanding  (outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** mat4_vector_transform: FAILED **");
         $finish;
      end
   end

   // Mostly no idle, sometimes a short gap, rarely a long stretch.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Signed value in [-2^bits, 2^bits).
   function automatic data_type small_value(int bits);
      return data_type'(int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits));
   endfunction

   // Mix of corners, full 32-bit noise and moderate magnitudes.
   function automatic data_type any_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return CORNERS[$urandom_range(0, 6)];
      if (r < 4)
         return data_type'($urandom());
      return small_value(20);
   endfunction

   // Back-pressure: rsp_ready holds each level for a random stretch.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if (stalls_on) begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
         ready_hold = idle_length();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one request and hold it until accepted. Payload is scrambled
   // during idle cycles; the block must ignore it while req_valid is low.
   task automatic send_vector(input data_type vx, input data_type vy,
                              input data_type vz, input data_type vw);
      int gap;
      gap = gaps_on ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_in_x  <= data_type'($urandom());
         req_in_y  <= data_type'($urandom());
         req_in_z  <= data_type'($urandom());
         req_in_w  <= data_type'($urandom());
         repeat (gap) @(negedge clock);
      end
      req_in_x  <= vx;
      req_in_y  <= vy;
      req_in_z  <= vz;
      req_in_w  <= vw;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random();
      send_vector(any_value(), any_value(), any_value(), any_value());
   endtask

   // Stop sending and wait for every outstanding result. The checker's count
   // is registered, so look only after the edge following the last accept.
   task automatic wait_all_results();
      @(negedge clock) req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Drain, then rewrite all eight registers. A final write to an index past
   // the register map must leave the matrix untouched.
   task automatic load_matrix(input matrix_kind_type kind);
      logic [REG_W-1:0] val;
      wait_all_results();
      for (int i = 0; i < NUM_REGS; i++) begin
         case (kind)
            MAT_IDENTITY:    val = REG_RESET[i];
            MAT_ZERO:        val = '0;
            MAT_ALL_NEG_ONE: val = '1;
            MAT_ALL_MIN:     val = {VMIN, VMIN};
            MAT_ALL_MAX:     val = {VMAX, VMAX};
            MAT_SMALL:       val = {small_value(18), small_value(18)};
            MAT_FULL:        val = {$urandom(), $urandom()};
            default:         val = {any_value(), any_value()};
         endcase
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= reg_idx_type'(i);
         csr_wdata <= val;
      end
      @(negedge clock);
      csr_addr  <= CSR_ADDR_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1));
      csr_wdata <= {$urandom(), $urandom()};
      @(negedge clock) csr_we <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_in_x  = '0;
      req_in_y  = '0;
      req_in_z  = '0;
      req_in_w  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Identity after reset: every output equals its input, including the
      // extremes and negative values that need the floor shift to come back.
      send_vector(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_vector(VMAX, VMAX, VMAX, VMAX);
      send_vector(VMIN, VMIN, VMIN, VMIN);
      send_vector(32'sd1, -32'sd1, ONE, -ONE);
      send_vector(VMAX, VMIN, -32'sd1, 32'sd1);

      // Every entry most negative: the sum reaches 2^64 in magnitude, so
      // both saturation directions and the wide sum path get exercised.
      load_matrix(MAT_ALL_MIN);
      send_vector(VMIN, VMIN, VMIN, VMIN);
      send_vector(VMAX, VMAX, VMAX, VMAX);
      send_vector(32'sd1, 32'sd0, 32'sd0, 32'sd0);
      send_vector(VMIN, VMAX, 32'sd0, -32'sd1);

      // Every entry -1 (register all ones): tiny products round toward
      // minus infinity.
      load_matrix(MAT_ALL_NEG_ONE);
      send_vector(32'sd1, 32'sd0, 32'sd0, 32'sd0);
      send_vector(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_vector(VMAX, VMAX, VMAX, VMAX);
      send_vector(VMIN, VMIN, VMIN, VMIN);

      load_matrix(MAT_ZERO);
      send_vector(VMAX, VMIN, VMAX, VMIN);
      send_vector(-32'sd1, -32'sd1, -32'sd1, -32'sd1);

      load_matrix(MAT_ALL_MAX);
      send_vector(VMAX, VMAX, VMAX, VMAX);
      send_vector(VMIN, VMIN, VMIN, VMIN);
      send_vector(VMAX, VMIN, 32'sd0, 32'sd0);
      send_vector(-32'sd1, 32'sd0, 32'sd0, 32'sd0);

      // Random phases, each on a fresh matrix. One phase runs at full rate on
      // both sides; one drains the pipeline halfway through.
      for (int p = 0; p < NUM_PHASES; p++) begin
         load_matrix(RANDOM_PLAN[p]);
         gaps_on   = (p != 2) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != 2) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 1 && n == ITEMS_PER_PHASE / 2)
               wait_all_results();
            send_random();
         end
      end

      wait_all_results();
      // keep clocking for a while to catch any stray result
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("** mat4_vector_transform: PASSED **");
      else
         $display("** mat4_vector_transform: FAILED **");
      $finish;
   end

endmodule

// ----- mat4_vector_transform.f -----
design/mvt_pkg.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/mat4_vector_transform.sv
tb/sv/mvt_result_checker.sv
tb/sv/tb.sv
